@@ rtl/core/utf8_code_point_decoder_assert.svh @@
// assertion macros used by the checker file
`ifndef UTF8_CODE_POINT_DECODER_ASSERT_SVH
`define UTF8_CODE_POINT_DECODER_ASSERT_SVH

// clocked assertion, held off while reset is asserted
`define UCPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked assertion that also applies during reset
`define UCPD_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/core/utf8cpd_pkg.sv @@
`default_nettype none
package utf8cpd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CpW    = 21;
  localparam int unsigned PendW  = 2;
  localparam int unsigned TdataW = 24;

  // decoder state carried between bytes
  typedef struct packed {
    logic [PendW-1:0] pending;
    logic [CpW-1:0]   partial;
    logic             bad;
  } dec_state_t;

  // one decoded character
  typedef struct packed {
    logic           valid;
    logic [CpW-1:0] code_point;
    logic           malformed;
  } dec_result_t;

  localparam logic [PendW-1:0] PendNone  = 2'd0;
  localparam logic [PendW-1:0] PendOne   = 2'd1;
  localparam logic [PendW-1:0] PendTwo   = 2'd2;
  localparam logic [PendW-1:0] PendThree = 2'd3;

endpackage
`default_nettype wire

@@ rtl/core/utf8cpd_step.sv @@
`default_nettype none
module utf8cpd_step (
  input  wire logic [utf8cpd_pkg::ByteW-1:0] text_byte,
  input  wire utf8cpd_pkg::dec_state_t       state_cur,
  output      utf8cpd_pkg::dec_state_t       state_nxt,
  output      utf8cpd_pkg::dec_result_t      result
);
  import utf8cpd_pkg::*;

  logic [CpW-1:0] shifted;

  assign shifted = {state_cur.partial[CpW-7:0], text_byte[5:0]};

  always_comb begin
    state_nxt         = state_cur;
    result.valid      = 1'b0;
    result.code_point = '0;
    result.malformed  = 1'b0;
    if (state_cur.pending != PendNone) begin
      // continuation byte: taken even when it is not 10xxxxxx
      if (state_cur.pending == PendOne) begin
        result.valid      = 1'b1;
        result.malformed  = state_cur.bad || (text_byte[7:6] != 2'b10);
        result.code_point = result.malformed ? '0 : shifted;
        state_nxt.pending = PendNone;
        state_nxt.partial = '0;
        state_nxt.bad     = 1'b0;
      end else begin
        state_nxt.pending = state_cur.pending - PendOne;
        state_nxt.partial = shifted;
        state_nxt.bad     = state_cur.bad || (text_byte[7:6] != 2'b10);
      end
    end else begin
      priority casez (text_byte)
        8'b0???_????: begin
          result.valid      = 1'b1;
          result.code_point = {{(CpW-ByteW){1'b0}}, text_byte};
        end
        8'b110?_????: begin
          state_nxt.pending = PendOne;
          state_nxt.partial = {{(CpW-5){1'b0}}, text_byte[4:0]};
          state_nxt.bad     = 1'b0;
        end
        8'b1110_????: begin
          state_nxt.pending = PendTwo;
          state_nxt.partial = {{(CpW-4){1'b0}}, text_byte[3:0]};
          state_nxt.bad     = 1'b0;
        end
        8'b1111_0???: begin
          state_nxt.pending = PendThree;
          state_nxt.partial = {{(CpW-3){1'b0}}, text_byte[2:0]};
          state_nxt.bad     = 1'b0;
        end
        default: begin
          // stray continuation or 11111xxx lead
          result.valid     = 1'b1;
          result.malformed = 1'b1;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/utf8_code_point_decoder.sv @@
// channel   dir  tdata                          tuser
// in_       in   [7:0] text_byte                -
// out_      out  [20:0] code_point, [23:21] 0   [0] malformed
//
// one byte per cycle while out_ is not stalled; a byte passes an input register
// and then a result register before its character shows on out_
// a byte that completes no character uses no output slot
// out_tready low holds the result; in_tready then drops only once the
// input register also holds a byte that needs the output slot
// rst_n is synchronous and clears the decoder state and both valid flags
`default_nettype none
module utf8_code_point_decoder (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output      logic                             in_tready,
  input  wire logic [utf8cpd_pkg::ByteW-1:0]    in_tdata,   // [7:0] text_byte
  output      logic                             out_tvalid,
  input  wire logic                             out_tready,
  output      logic [utf8cpd_pkg::TdataW-1:0]   out_tdata,  // [20:0] code_point
  output      logic                             out_tuser   // [0] malformed
);
  import utf8cpd_pkg::*;

  logic             in_valid_r;
  logic [ByteW-1:0] in_byte_r;
  dec_state_t       state_r, state_nxt;
  dec_result_t      result;
  logic             out_valid_r;
  logic [CpW-1:0]   out_cp_r;
  logic             out_bad_r;
  logic             advance;

  utf8cpd_step u_step (
    .text_byte (in_byte_r),
    .state_cur (state_r),
    .state_nxt (state_nxt),
    .result    (result)
  );

  // the held byte moves on unless it has a result and the slot is taken
  assign advance   = in_valid_r && (!result.valid || !out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && result.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (advance && result.valid) begin
      out_cp_r  <= result.code_point;
      out_bad_r <= result.malformed;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(TdataW-CpW){1'b0}}, out_cp_r};
  assign out_tuser  = out_bad_r;

endmodule
`default_nettype wire

@@ rtl/core/utf8cpd_checker.sv @@
`default_nettype none
`include "utf8_code_point_decoder_assert.svh"
module utf8cpd_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_tvalid,
  input wire logic                           in_tready,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [utf8cpd_pkg::TdataW-1:0] out_tdata,
  input wire logic                           out_tuser
);
  import utf8cpd_pkg::*;

  logic              in_req;
  logic              out_hold;
  logic              cp_zero;
  logic              pad_zero;
  logic [TdataW:0]   out_word;

  assign in_req   = in_tvalid && in_tready;
  assign out_hold = out_tvalid && !out_tready;
  assign cp_zero  = (out_tdata[CpW-1:0] == '0);
  assign pad_zero = (out_tdata[TdataW-1:CpW] == '0);
  assign out_word = {out_tuser, out_tdata};

  // reset empties the result register
  `UCPD_ASSERT_RST(a_idle_after_reset, !rst_n |=> !out_tvalid, "result valid after reset")
  `UCPD_ASSERT(a_bad_is_zero, (out_tvalid && out_tuser) |-> cp_zero, "malformed with code point")
  `UCPD_ASSERT(a_pad_zero, out_tvalid |-> pad_zero, "nonzero padding bits")
  `UCPD_ASSERT(a_stall_hold, out_hold |=> (out_tvalid && $stable(out_word)), "held result changed")
  // a request seen right after reset release cannot have a result yet
  `UCPD_ASSERT(a_no_early, ($past(!rst_n) && in_req) |=> !out_tvalid, "early result")

endmodule

bind utf8_code_point_decoder utf8cpd_checker u_utf8cpd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire

@@ verif/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import utf8cpd_pkg::*;

  // byte prefixes of the utf-8 encoding
  localparam logic       AsciiTag = 1'b0;
  localparam logic [1:0] ContTag  = 2'b10;
  localparam logic [2:0] Lead2Tag = 3'b110;
  localparam logic [3:0] Lead3Tag = 4'b1110;
  localparam logic [4:0] Lead4Tag = 5'b11110;

  localparam int TextBytes  = 600;
  localparam int CalmAfter  = 480;
  localparam int HoldAt     = 300;
  localparam int LongHold   = 160;
  localparam int QuietLimit = 2000;
  localparam int DrainTail  = 10;

  typedef struct {
    logic [CpW-1:0] code_point;
    logic           malformed;
  } char_t;

  class utf8_char_scoreboard;
    logic [PendW-1:0] pending;
    logic [CpW-1:0]   partial;
    logic             bad;
    char_t            waiting[$];
    int               errors;
    int               chars_checked;
    int               malformed_seen;

    function new();
      pending = PendNone;
      partial = '0;
      bad = 1'b0;
      errors = 0;
      chars_checked = 0;
      malformed_seen = 0;
    endfunction

    function void push_char(logic [CpW-1:0] cp, logic flag);
      char_t c;
      c.code_point = flag ? '0 : cp;
      c.malformed = flag;
      waiting.push_back(c);
    endfunction

    // advance the decoder by one accepted byte
    function void note_byte(logic [ByteW-1:0] b);
      if (pending != PendNone) begin
        if (b[7:6] != ContTag) bad = 1'b1;
        partial = {partial[CpW-7:0], b[5:0]};
        pending = pending - 1'b1;
        if (pending == PendNone) begin
          push_char(partial, bad);
          partial = '0;
          bad = 1'b0;
        end
      end else if (b[7] == AsciiTag) begin
        push_char({{(CpW-ByteW){1'b0}}, b}, 1'b0);
      end else if (b[7:5] == Lead2Tag) begin
        pending = PendOne;
        partial = {{(CpW-5){1'b0}}, b[4:0]};
        bad = 1'b0;
      end else if (b[7:4] == Lead3Tag) begin
        pending = PendTwo;
        partial = {{(CpW-4){1'b0}}, b[3:0]};
        bad = 1'b0;
      end else if (b[7:3] == Lead4Tag) begin
        pending = PendThree;
        partial = {{(CpW-3){1'b0}}, b[2:0]};
        bad = 1'b0;
      end else begin
        // stray continuation or invalid lead
        push_char('0, 1'b1);
      end
    endfunction

    task report_mismatch(string what, int unsigned got, int unsigned want);
      $display("mismatch on %s: got %0h, expected %0h", what, got, want);
      errors++;
    endtask

    task check_char(logic [TdataW-1:0] data, logic flag);
      char_t c;
      if (waiting.size() == 0) begin
        report_mismatch("unexpected character", data, 0);
        return;
      end
      c = waiting.pop_front();
      if (data[CpW-1:0] != c.code_point)
        report_mismatch("code_point", data[CpW-1:0], c.code_point);
      if (data[TdataW-1:CpW] != '0)
        report_mismatch("tdata padding", data[TdataW-1:CpW], 0);
      if (flag != c.malformed)
        report_mismatch("malformed", flag, c.malformed);
      chars_checked++;
      if (flag) malformed_seen++;
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [ByteW-1:0]  in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [TdataW-1:0] out_tdata;
  logic              out_tuser;

  utf8_char_scoreboard sb;
  logic [ByteW-1:0]    sample_text[$];
  bit                  src_idle = 1'b1;
  bit                  sink_idle = 1'b1;
  bit                  long_hold_req = 1'b0;
  int                  bytes_sent = 0;
  int                  quiet_cycles = 0;

  utf8_code_point_decoder uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // call at a falling edge; returns at the falling edge after the request is taken
  task automatic send_byte(input logic [ByteW-1:0] b);
    if (src_idle && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    do @(posedge clk); while (!in_tready);
    sb.note_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  // mostly well-formed characters with random payload, some noise and broken sequences
  task automatic send_random_char();
    int kind;
    int len;
    logic [ByteW-1:0] b;
    kind = $urandom_range(0, 99);
    len = $urandom_range(1, 4);
    if (kind >= 80 && kind < 90) begin
      send_byte(ByteW'($urandom));
      return;
    end
    if (kind >= 90 && len == 1) len = 2;
    case (len)
      1: b = {AsciiTag, 7'($urandom)};
      2: b = {Lead2Tag, 5'($urandom)};
      3: b = {Lead3Tag, 4'($urandom)};
      default: b = {Lead4Tag, 3'($urandom)};
    endcase
    send_byte(b);
    for (int i = 1; i < len; i++) begin
      if (kind >= 90 && $urandom_range(0, 1) == 0) b = ByteW'($urandom);
      else b = {ContTag, 6'($urandom)};
      send_byte(b);
    end
  endtask

  initial begin : result_sink
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall = LongHold;
      end else if (stall == 0 && sink_idle && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 19);
      end
      if (stall != 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_char(out_tdata, out_tuser);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("no request moved for %0d cycles", QuietLimit);
      $display("utf8_code_point_decoder regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    sb = new();
    // nul, top ascii, 2/3/4-byte characters, largest 21-bit value,
    // stray continuations, invalid leads, bad continuation inside a sequence
    sample_text = '{8'h00, 8'h7F,
                    8'hC2, 8'hA9,
                    8'hE2, 8'h82, 8'hAC,
                    8'hF0, 8'h9F, 8'h98, 8'h80,
                    8'hF7, 8'hBF, 8'hBF, 8'hBF,
                    8'h80, 8'hBF,
                    8'hF8, 8'hFF,
                    8'hE2, 8'h41, 8'hAC,
                    8'hC3, 8'hC3};
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (sample_text[i]) send_byte(sample_text[i]);

    while (bytes_sent < TextBytes) begin
      if (bytes_sent >= HoldAt && bytes_sent < HoldAt + 4 && !long_hold_req) begin
        // receiver holds off while bytes keep coming so the input stalls
        long_hold_req = 1'b1;
      end
      if (bytes_sent >= CalmAfter) begin
        src_idle = 1'b0;
        sink_idle = 1'b0;
      end
      send_random_char();
    end
    in_tvalid <= 1'b0;

    while (sb.waiting.size() != 0) @(negedge clk);
    repeat (DrainTail) @(negedge clk);
    if (sb.waiting.size() != 0)
      sb.report_mismatch("characters never delivered", 0, sb.waiting.size());

    $display("decoded %0d bytes into %0d characters, %0d flagged malformed",
             bytes_sent, sb.chars_checked, sb.malformed_seen);
    $display("random gaps on both sides plus one %0d-cycle output hold", LongHold);
    if (sb.errors == 0) begin
      $display("utf8_code_point_decoder regression: pass");
    end else begin
      $display("utf8_code_point_decoder regression: fail");
    end
    $finish;
  end

endmodule
